// ===== design/ttg_pkg.sv =====
// ttg_pkg: shared types and constants of the triangle tangent generator
// no dependencies
`default_nettype none
package ttg_pkg;
	localparam int DELTA_W = 33;
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	// exact edge and texcoord deltas of one triangle
	typedef struct packed {
		logic signed [DELTA_W-1:0] du1;
		logic signed [DELTA_W-1:0] dv1;
		logic signed [DELTA_W-1:0] du2;
		logic signed [DELTA_W-1:0] dv2;
		logic signed [DELTA_W-1:0] e1x;
		logic signed [DELTA_W-1:0] e1y;
		logic signed [DELTA_W-1:0] e1z;
		logic signed [DELTA_W-1:0] e2x;
		logic signed [DELTA_W-1:0] e2y;
		logic signed [DELTA_W-1:0] e2z;
	} delta_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} back_state_t;
endpackage
`default_nettype wire

// ===== design/ttg_vertex_if.sv =====
// ttg_vertex_if: vertex channel, valid/ready with vertex payload
// depends on nothing
`default_nettype none
interface ttg_vertex_if #(parameter int INDEX_BITS = 16);
	logic                    valid;
	logic                    ready;
	logic [INDEX_BITS-1:0]   vertex_index;
	logic signed [31:0]      position_x;
	logic signed [31:0]      position_y;
	logic signed [31:0]      position_z;
	logic signed [31:0]      tex_u;
	logic signed [31:0]      tex_v;
	logic                    last_of_mesh;
	modport source(output valid, vertex_index, position_x, position_y, position_z,
		tex_u, tex_v, last_of_mesh, input ready);
	modport sink(input valid, vertex_index, position_x, position_y, position_z,
		tex_u, tex_v, last_of_mesh, output ready);
endinterface
`default_nettype wire

// ===== design/ttg_tangent_if.sv =====
// ttg_tangent_if: tangent channel, valid/ready with tangent payload
// depends on nothing
`default_nettype none
interface ttg_tangent_if #(parameter int INDEX_BITS = 16);
	logic                    valid;
	logic                    ready;
	logic [INDEX_BITS-1:0]   corner_index_a;
	logic [INDEX_BITS-1:0]   corner_index_b;
	logic [INDEX_BITS-1:0]   corner_index_c;
	logic signed [15:0]      tangent_x;
	logic signed [15:0]      tangent_y;
	logic signed [15:0]      tangent_z;
	logic                    degenerate;
	modport source(output valid, corner_index_a, corner_index_b, corner_index_c,
		tangent_x, tangent_y, tangent_z, degenerate, input ready);
	modport sink(input valid, corner_index_a, corner_index_b, corner_index_c,
		tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== design/ttg_front.sv =====
// ttg_front: holds the first two corners and forms the deltas on the third
// depends on ttg_pkg and ttg_vertex_if
`default_nettype none
module ttg_front #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	ttg_vertex_if.sink                     vertex,
	output logic                           tri_valid,
	input  wire logic                      tri_ready,
	output ttg_pkg::delta_t                tri_delta,
	output logic [3*INDEX_BITS-1:0]        tri_idx
);
	logic [1:0] count_q;
	logic signed [31:0] px_q [2];
	logic signed [31:0] py_q [2];
	logic signed [31:0] pz_q [2];
	logic signed [31:0] tu_q [2];
	logic signed [31:0] tv_q [2];
	logic [INDEX_BITS-1:0] idx_q [2];
	logic third;
	logic xfer;

	function automatic logic signed [32:0] sub33(logic signed [31:0] a, logic signed [31:0] b);
		return $signed({a[31], a}) - $signed({b[31], b});
	endfunction

	assign third        = (count_q == 2'd2);
	assign vertex.ready = !third || tri_ready;
	assign tri_valid    = vertex.valid && third;
	assign xfer         = vertex.valid && vertex.ready;

	always_comb begin
		tri_delta.e1x = sub33(px_q[1], px_q[0]);
		tri_delta.e1y = sub33(py_q[1], py_q[0]);
		tri_delta.e1z = sub33(pz_q[1], pz_q[0]);
		tri_delta.e2x = sub33(vertex.position_x, px_q[0]);
		tri_delta.e2y = sub33(vertex.position_y, py_q[0]);
		tri_delta.e2z = sub33(vertex.position_z, pz_q[0]);
		tri_delta.du1 = sub33(tu_q[1], tu_q[0]);
		tri_delta.dv1 = sub33(tv_q[1], tv_q[0]);
		tri_delta.du2 = sub33(vertex.tex_u, tu_q[0]);
		tri_delta.dv2 = sub33(vertex.tex_v, tv_q[0]);
		tri_idx = {vertex.vertex_index, idx_q[1], idx_q[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (xfer) begin
			if (third || vertex.last_of_mesh) begin
				count_q <= 2'd0;
			end else begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	// corner storage, no reset
	always_ff @(posedge clk) begin
		if (xfer && !third) begin
			px_q[count_q[0]]  <= vertex.position_x;
			py_q[count_q[0]]  <= vertex.position_y;
			pz_q[count_q[0]]  <= vertex.position_z;
			tu_q[count_q[0]]  <= vertex.tex_u;
			tv_q[count_q[0]]  <= vertex.tex_v;
			idx_q[count_q[0]] <= vertex.vertex_index;
		end
	end
endmodule
`default_nettype wire

// ===== design/ttg_queue.sv =====
// ttg_queue: two-entry triangle queue between front and back
// depends on nothing
`default_nettype none
module ttg_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      out_data
);
	logic [W-1:0] mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] fill_q;
	logic push, pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_data  = mem_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_data;
	end
endmodule
`default_nettype wire

// ===== design/ttg_back.sv =====
// ttg_back: sequencer for products, normalization, square root and divides
// depends on ttg_pkg and ttg_tangent_if
`default_nettype none
module ttg_back #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rec_valid,
	output logic                            rec_ready,
	input  wire ttg_pkg::delta_t            rec_delta,
	input  wire logic [3*INDEX_BITS-1:0]    rec_idx,
	ttg_tangent_if.source                   tangent
);
	ttg_pkg::back_state_t state_q, state_d;
	ttg_pkg::delta_t d_q;
	logic [3*INDEX_BITS-1:0] idx_q;
	logic [3:0]  cnt_q;
	logic [63:0] prod_q;
	logic        pneg_q;
	logic signed [65:0] first_q;
	logic        detz_q;
	logic [2:0]  tneg_q;
	logic [64:0] tmag_q [3];
	logic [61:0] acc_q;
	logic [63:0] v_q, r_q, bit_q;
	logic [45:0] rem_q, dvs_q;
	logic [13:0] quo_q;
	logic [1:0]  k_q;
	logic [3:0]  dstep_q;
	logic signed [15:0] tan_q [3];
	logic        degen_q;
	logic        out_valid_q;

	logic signed [32:0] op_a, op_b;
	logic [31:0] mul_a, mul_b;
	logic [64:0] orv;
	logic signed [65:0] sv, diff;
	logic [64:0] dmag;
	logic [63:0] trial;
	logic        qbit;
	logic [14:0] qfin, qclip;
	logic        load_out;

	function automatic logic [31:0] mag33(logic signed [32:0] x);
		logic signed [32:0] n;
		n = -x;
		return x[32] ? n[31:0] : x[31:0];
	endfunction

	assign orv   = tmag_q[0] | tmag_q[1] | tmag_q[2];
	assign sv    = pneg_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
	assign diff  = first_q - sv;
	assign dmag  = diff[65] ? 65'(-diff) : diff[64:0];
	assign trial = r_q + bit_q;
	assign qbit  = (rem_q >= dvs_q);
	assign qfin  = {quo_q, qbit};
	assign qclip = (qfin > ttg_pkg::ONE_Q14) ? ttg_pkg::ONE_Q14 : qfin;

	// product operand schedule
	always_comb begin
		op_a = d_q.du1;
		op_b = d_q.dv2;
		unique case (cnt_q[2:0])
			3'd0: begin op_a = d_q.du1; op_b = d_q.dv2; end
			3'd1: begin op_a = d_q.du2; op_b = d_q.dv1; end
			3'd2: begin op_a = d_q.dv2; op_b = d_q.e1x; end
			3'd3: begin op_a = d_q.dv1; op_b = d_q.e2x; end
			3'd4: begin op_a = d_q.dv2; op_b = d_q.e1y; end
			3'd5: begin op_a = d_q.dv1; op_b = d_q.e2y; end
			3'd6: begin op_a = d_q.dv2; op_b = d_q.e1z; end
			3'd7: begin op_a = d_q.dv1; op_b = d_q.e2z; end
			default: begin op_a = d_q.du1; op_b = d_q.dv2; end
		endcase
	end

	always_comb begin
		if (state_q == ttg_pkg::ST_SQ) begin
			mul_a = {2'b00, tmag_q[cnt_q[1:0]][29:0]};
			mul_b = {2'b00, tmag_q[cnt_q[1:0]][29:0]};
		end else begin
			mul_a = mag33(op_a);
			mul_b = mag33(op_b);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttg_pkg::ST_IDLE: if (rec_valid) state_d = ttg_pkg::ST_MUL;
			ttg_pkg::ST_MUL:  if (cnt_q == 4'd8) state_d = ttg_pkg::ST_NORM;
			ttg_pkg::ST_NORM: begin
				if (detz_q || orv == 65'd0) begin
					state_d = ttg_pkg::ST_OUT;
				end else if (orv[64:30] == 35'd0 && orv[29]) begin
					state_d = ttg_pkg::ST_SQ;
				end
			end
			ttg_pkg::ST_SQ:   if (cnt_q == 4'd3) state_d = ttg_pkg::ST_SQRT;
			ttg_pkg::ST_SQRT: if (bit_q[0]) state_d = ttg_pkg::ST_DIV;
			ttg_pkg::ST_DIV:  if (dstep_q == 4'd15 && k_q == 2'd2) state_d = ttg_pkg::ST_OUT;
			ttg_pkg::ST_OUT:  if (!out_valid_q || tangent.ready) state_d = ttg_pkg::ST_IDLE;
			default:          state_d = ttg_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rec_ready = (state_q == ttg_pkg::ST_IDLE);
		load_out  = (state_q == ttg_pkg::ST_OUT) && (!out_valid_q || tangent.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (tangent.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ttg_pkg::ST_IDLE: begin
				d_q     <= rec_delta;
				idx_q   <= rec_idx;
				cnt_q   <= 4'd0;
				degen_q <= 1'b0;
			end
			ttg_pkg::ST_MUL: begin
				cnt_q  <= cnt_q + 4'd1;
				prod_q <= mul_a * mul_b;
				pneg_q <= op_a[32] ^ op_b[32];
				unique case (cnt_q)
					4'd1, 4'd3, 4'd5, 4'd7: first_q <= sv;
					4'd2: detz_q <= (diff == 66'sd0);
					4'd4: begin tneg_q[0] <= diff[65]; tmag_q[0] <= dmag; end
					4'd6: begin tneg_q[1] <= diff[65]; tmag_q[1] <= dmag; end
					4'd8: begin tneg_q[2] <= diff[65]; tmag_q[2] <= dmag; end
					default: ;
				endcase
			end
			ttg_pkg::ST_NORM: begin
				cnt_q <= 4'd0;
				if (detz_q || orv == 65'd0) begin
					degen_q  <= 1'b1;
					tan_q[0] <= 16'sd0;
					tan_q[1] <= 16'sd0;
					tan_q[2] <= 16'sd0;
				end else if (orv[64:30] != 35'd0) begin
					// truncating shift toward a 30-bit largest magnitude
					tmag_q[0] <= tmag_q[0] >> 1;
					tmag_q[1] <= tmag_q[1] >> 1;
					tmag_q[2] <= tmag_q[2] >> 1;
				end else if (!orv[29]) begin
					tmag_q[0] <= tmag_q[0] << 1;
					tmag_q[1] <= tmag_q[1] << 1;
					tmag_q[2] <= tmag_q[2] << 1;
				end
			end
			ttg_pkg::ST_SQ: begin
				cnt_q  <= cnt_q + 4'd1;
				prod_q <= mul_a * mul_b;
				if (cnt_q == 4'd0) begin
					acc_q <= 62'd0;
				end else if (cnt_q == 4'd3) begin
					v_q   <= {2'b00, acc_q + prod_q[61:0]};
					r_q   <= 64'd0;
					bit_q <= 64'd1 << 62;
				end else begin
					acc_q <= acc_q + prod_q[61:0];
				end
			end
			ttg_pkg::ST_SQRT: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q   <= bit_q >> 2;
				k_q     <= 2'd0;
				dstep_q <= 4'd0;
			end
			ttg_pkg::ST_DIV: begin
				if (dstep_q == 4'd0) begin
					// m * 16384 + len / 2, divisor len aligned to quotient bit 14
					rem_q   <= {2'b00, tmag_q[k_q][29:0], 14'd0} + {15'd0, r_q[31:1]};
					dvs_q   <= {r_q[31:0], 14'd0};
					dstep_q <= 4'd1;
				end else begin
					if (qbit) rem_q <= rem_q - dvs_q;
					dvs_q <= dvs_q >> 1;
					quo_q <= qfin[13:0];
					if (dstep_q == 4'd15) begin
						// output sign is the opposite of the raw tangent sign
						tan_q[k_q] <= tneg_q[k_q] ? $signed({1'b0, qclip})
							: -$signed({1'b0, qclip});
						k_q     <= k_q + 2'd1;
						dstep_q <= 4'd0;
					end else begin
						dstep_q <= dstep_q + 4'd1;
					end
				end
			end
			ttg_pkg::ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			tangent.corner_index_a <= idx_q[INDEX_BITS-1:0];
			tangent.corner_index_b <= idx_q[2*INDEX_BITS-1:INDEX_BITS];
			tangent.corner_index_c <= idx_q[3*INDEX_BITS-1:2*INDEX_BITS];
			tangent.tangent_x      <= tan_q[0];
			tangent.tangent_y      <= tan_q[1];
			tangent.tangent_z      <= tan_q[2];
			tangent.degenerate     <= degen_q;
		end
	end

	assign tangent.valid = out_valid_q;
endmodule
`default_nettype wire

// ===== design/triangle_tangent_generator_core.sv =====
// triangle tangent generator: vertex stream in, one unit tangent per triangle out, zero if degenerate
// throughput: one triangle per back sequence (products, normalize, squares, square root and
// three divides), the back taking the next triangle only when idle; the front takes a vertex
// per cycle unless the queue is full
// reset: asynchronous, clears corner count, queue pointers and fill, back state, output valid
// depends on ttg_pkg, ttg_vertex_if, ttg_tangent_if, ttg_front, ttg_queue, ttg_back
`default_nettype none
module triangle_tangent_generator_core #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ttg_vertex_if.sink      vertex,
	ttg_tangent_if.source   tangent
);
	localparam int REC_W = 3*INDEX_BITS + $bits(ttg_pkg::delta_t);

	// front to queue
	logic                    f_valid, f_ready;
	ttg_pkg::delta_t         f_delta;
	logic [3*INDEX_BITS-1:0] f_idx;

	// queue to back
	logic                    b_valid, b_ready;
	logic [REC_W-1:0]        q_rdata;
	ttg_pkg::delta_t         b_delta;
	logic [3*INDEX_BITS-1:0] b_idx;

	// front: corner holding and delta forming, stalls only on a full queue
	ttg_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vertex    (vertex),
		.tri_valid (f_valid),
		.tri_ready (f_ready),
		.tri_delta (f_delta),
		.tri_idx   (f_idx)
	);

	// two triangles of slack between front and back
	ttg_queue #(.W(REC_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_idx, f_delta}),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (q_rdata)
	);

	assign b_delta = q_rdata[$bits(ttg_pkg::delta_t)-1:0];
	assign b_idx   = q_rdata[REC_W-1:$bits(ttg_pkg::delta_t)];

	// back: shared multiplier, square root and divider under one sequencer,
	// with the result register on the tangent side
	ttg_back #(.INDEX_BITS(INDEX_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (b_valid),
		.rec_ready (b_ready),
		.rec_delta (b_delta),
		.rec_idx   (b_idx),
		.tangent   (tangent)
	);
endmodule
`default_nettype wire

// ===== design/ttg_checker.sv =====
// ttg_checker: port-level checks on the tangent channel
// bound to triangle_tangent_generator_core
`default_nettype none
module ttg_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              valid,
	input wire logic              ready,
	input wire logic signed [15:0] tx,
	input wire logic signed [15:0] ty,
	input wire logic signed [15:0] tz,
	input wire logic              degenerate
);
	// a pending result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("tangent valid dropped before transfer");

	// degenerate triangles carry a zero tangent
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && degenerate |-> tx == 16'sd0 && ty == 16'sd0 && tz == 16'sd0)
		else $error("degenerate result with nonzero tangent");

	// a normalized tangent is never all zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !degenerate |-> tx != 16'sd0 || ty != 16'sd0 || tz != 16'sd0)
		else $error("normalized tangent is zero");

	// components stay within one in Q2.14
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> tx <= 16'sd16384 && tx >= -16'sd16384 && ty <= 16'sd16384
			&& ty >= -16'sd16384 && tz <= 16'sd16384 && tz >= -16'sd16384)
		else $error("tangent component out of range");
endmodule

bind triangle_tangent_generator_core ttg_checker u_ttg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (tangent.valid),
	.ready      (tangent.ready),
	.tx         (tangent.tangent_x),
	.ty         (tangent.tangent_y),
	.tz         (tangent.tangent_z),
	.degenerate (tangent.degenerate)
);
`default_nettype wire

// ===== tb/sv/ttg_tb_checker.sv =====
// ttg_tb_checker: watches the vertex and tangent channels, predicts each tangent and compares
// depends on ttg_vertex_if, ttg_tangent_if
`default_nettype none
module ttg_tb_checker #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ttg_vertex_if       vertex,
	ttg_tangent_if      tangent,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [INDEX_BITS-1:0] ia;
		logic [INDEX_BITS-1:0] ib;
		logic [INDEX_BITS-1:0] ic;
		logic signed [15:0]    tx;
		logic signed [15:0]    ty;
		logic signed [15:0]    tz;
		logic                  degen;
	} tangent_exp_t;

	tangent_exp_t expected_tangents[$];

	logic signed [32:0]    keep_pos[6];
	logic signed [32:0]    keep_tex[4];
	logic [INDEX_BITS-1:0] keep_idx[2];
	int                    corner_n;

	assign pending_count = expected_tangents.size();

	// bit length of a 66-bit magnitude
	function automatic int bit_length(logic [65:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 66; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// tangent of the triangle closed by the current corner: -T/|T|, or zero with degen set if degenerate
	function automatic tangent_exp_t tangent_of(logic signed [32:0] p[3],
			logic signed [32:0] u, logic signed [32:0] v, logic [INDEX_BITS-1:0] idx);
		tangent_exp_t r;
		logic signed [32:0] e1[3], e2[3];
		logic signed [32:0] du1, dv1, du2, dv2;
		logic signed [67:0] det;
		logic signed [67:0] t[3];
		logic [65:0] mag[3];
		logic [63:0] m[3], sum, len, q;
		logic [127:0] wide;
		int bmax, b;
		logic neg;
		for (int k = 0; k < 3; k++) begin
			e1[k] = keep_pos[3 + k] - keep_pos[k];
			e2[k] = p[k] - keep_pos[k];
		end
		du1 = keep_tex[2] - keep_tex[0];
		dv1 = keep_tex[3] - keep_tex[1];
		du2 = u - keep_tex[0];
		dv2 = v - keep_tex[1];
		det = 68'(du1) * 68'(dv2) - 68'(du2) * 68'(dv1);
		bmax = 0;
		for (int k = 0; k < 3; k++) begin
			t[k] = 68'(dv2) * 68'(e1[k]) - 68'(dv1) * 68'(e2[k]);
			mag[k] = t[k] < 0 ? 66'(-t[k]) : 66'(t[k]);
			b = bit_length(mag[k]);
			if (b > bmax) bmax = b;
		end
		r.ia = keep_idx[0];
		r.ib = keep_idx[1];
		r.ic = idx;
		r.tx = 0;
		r.ty = 0;
		r.tz = 0;
		r.degen = (det == 0) || (bmax == 0);
		if (r.degen) return r;
		for (int k = 0; k < 3; k++)
			m[k] = bmax > 30 ? 64'(mag[k] >> (bmax - 30)) : 64'(mag[k] << (30 - bmax));
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(sum);
		for (int k = 0; k < 3; k++) begin
			wide = (128'(m[k]) * 128'd16384 + 128'(len / 2)) / 128'(len);
			q = wide > 128'd16384 ? 64'd16384 : 64'(wide);
			neg = !(t[k] < 0);
			if (k == 0) r.tx = neg ? -16'(q) : 16'(q);
			if (k == 1) r.ty = neg ? -16'(q) : 16'(q);
			if (k == 2) r.tz = neg ? -16'(q) : 16'(q);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tangent_exp_t e, got;
		logic signed [32:0] p[3];
		if (!arst_n) begin
			corner_n <= 0;
			fail_count <= 0;
		end else begin
			if (vertex.valid && vertex.ready) begin
				p[0] = 33'(vertex.position_x);
				p[1] = 33'(vertex.position_y);
				p[2] = 33'(vertex.position_z);
				if (corner_n < 2) begin
					for (int k = 0; k < 3; k++) keep_pos[corner_n * 3 + k] = p[k];
					keep_tex[corner_n * 2] = 33'(vertex.tex_u);
					keep_tex[corner_n * 2 + 1] = 33'(vertex.tex_v);
					keep_idx[corner_n] = vertex.vertex_index;
					corner_n <= vertex.last_of_mesh ? 0 : corner_n + 1;
				end else begin
					corner_n <= 0;
					expected_tangents.push_back(tangent_of(p, 33'(vertex.tex_u),
						33'(vertex.tex_v), vertex.vertex_index));
				end
			end
			if (tangent.valid && tangent.ready) begin
				got = '{tangent.corner_index_a, tangent.corner_index_b,
					tangent.corner_index_c, tangent.tangent_x, tangent.tangent_y,
					tangent.tangent_z, tangent.degenerate};
				if (expected_tangents.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected tangent transfer %h", got);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_tangents.pop_front();
					if (e !== got) begin
						if (fail_count < 10)
							$display("tangent mismatch: idx %0d %0d %0d t %0d %0d %0d d %b / got idx %0d %0d %0d t %0d %0d %0d d %b",
								e.ia, e.ib, e.ic, e.tx, e.ty, e.tz, e.degen,
								got.ia, got.ib, got.ic, got.tx, got.ty, got.tz, got.degen);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: vertex stimulus and verdict for triangle_tangent_generator_core
// depends on ttg_pkg, ttg_vertex_if, ttg_tangent_if, ttg_tb_checker and the core
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	bit   long_hold;     // receiver held off for a long stretch
	bit   hold_done;

	ttg_vertex_if  #(.INDEX_BITS(16)) vtx ();
	ttg_tangent_if #(.INDEX_BITS(16)) tan ();

	triangle_tangent_generator_core #(.INDEX_BITS(16)) i_dut (
		.clk(clk), .arst_n(arst_n), .vertex(vtx), .tangent(tan)
	);

	ttg_tb_checker #(.INDEX_BITS(16)) i_checker (
		.clk(clk), .arst_n(arst_n), .vertex(vtx), .tangent(tan),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly short, sometimes long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return 32'($signed($urandom_range(0, 1023)) - 512) << 10;
			default: return $urandom;
		endcase
	endfunction

	// one vertex transfer; holds valid until accepted
	task automatic send_vertex(logic [15:0] idx, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [31:0] u, logic [31:0] v, logic last);
		vtx.valid        <= 1'b1;
		vtx.vertex_index <= idx;
		vtx.position_x   <= px;
		vtx.position_y   <= py;
		vtx.position_z   <= pz;
		vtx.tex_u        <= u;
		vtx.tex_v        <= v;
		vtx.last_of_mesh <= last;
		do @(posedge clk); while (!vtx.ready);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			vtx.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_vertex(logic last);
		send_vertex(16'($urandom), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), last);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		tan.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold && !hold_done) begin
				tan.ready <= 1'b0;
				repeat (800) @(posedge clk);
				hold_done = 1;
			end else begin
				tan.ready <= 1'b1;
				@(posedge clk);
				if ($urandom_range(0, 3) == 0) begin
					tan.ready <= 1'b0;
					repeat (gap_len() + 1) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int sent;
		int r;
		bit drained;
		vtx.valid = 0;
		vtx.vertex_index = 0;
		vtx.position_x = 0;
		vtx.position_y = 0;
		vtx.position_z = 0;
		vtx.tex_u = 0;
		vtx.tex_v = 0;
		vtx.last_of_mesh = 0;
		long_hold = 0;
		hold_done = 0;
		drained = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: a plain triangle, extremes, degenerate cases, dropped corners
		send_vertex(16'd0, 0, 0, 0, 0, 0, 1'b0);
		send_vertex(16'd1, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0);
		send_vertex(16'd2, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b0);
		send_vertex(16'hffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 1'b0);
		send_vertex(16'h0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_vertex(16'haaaa, 32'h7fff_ffff, 32'h8000_0000, 0,
			32'h8000_0000, 32'h7fff_ffff, 1'b1);
		// zero determinant: collinear texcoords
		send_vertex(16'd10, 0, 0, 0, 0, 0, 1'b0);
		send_vertex(16'd11, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b0);
		send_vertex(16'd12, 0, 32'h0001_0000, 0, 32'h0002_0000, 32'h0002_0000, 1'b0);
		// zero tangent: all positions equal
		send_vertex(16'd20, 32'h1234, 32'h1234, 32'h1234, 0, 0, 1'b0);
		send_vertex(16'd21, 32'h1234, 32'h1234, 32'h1234, 32'h0001_0000, 0, 1'b0);
		send_vertex(16'd22, 32'h1234, 32'h1234, 32'h1234, 0, 32'h0001_0000, 1'b0);
		// last on the first corner, then on the second
		send_vertex(16'd30, 1, 2, 3, 4, 5, 1'b1);
		send_vertex(16'd31, 1, 2, 3, 4, 5, 1'b0);
		send_vertex(16'd32, 7, 8, 9, 10, 11, 1'b1);
		// tiny tangent, shifted up
		send_vertex(16'd40, 0, 0, 0, 0, 0, 1'b0);
		send_vertex(16'd41, 1, 0, 0, 0, 1, 1'b0);
		send_vertex(16'd42, 0, 1, 0, 1, 0, 1'b1);
		idle_gap(1);

		// random: whole triangles mostly, with a few broken meshes
		sent = 0;
		while (sent < 1500) begin
			if (sent >= 600 && !long_hold) long_hold = 1;
			if (sent >= 1000 && !drained) begin
				drained = 1;
				vtx.valid <= 1'b0;
				while (pending_count != 0) @(posedge clk);
			end
			r = $urandom_range(0, 19);
			if (r == 0) begin
				random_vertex(1'b1);
				sent += 1;
			end else if (r == 1) begin
				random_vertex(1'b0);
				idle_gap(gap_len());
				random_vertex(1'b1);
				sent += 2;
			end else begin
				random_vertex(1'b0);
				idle_gap(long_hold && !hold_done ? 0 : gap_len());
				random_vertex(1'b0);
				idle_gap(long_hold && !hold_done ? 0 : gap_len());
				random_vertex(1'($urandom_range(0, 1)));
				sent += 3;
			end
			idle_gap(long_hold && !hold_done ? 0 : gap_len());
		end
		vtx.valid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("triangle_tangent_generator_core regression: pass");
		else
			$display("triangle_tangent_generator_core regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("triangle_tangent_generator_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
design/ttg_pkg.sv
design/ttg_vertex_if.sv
design/ttg_tangent_if.sv
design/ttg_front.sv
design/ttg_queue.sv
design/ttg_back.sv
design/triangle_tangent_generator_core.sv
design/ttg_checker.sv
tb/sv/ttg_tb_checker.sv
tb/sv/testbench.sv
